>>> src/wpd_pkg.sv
// Package for the waveform peak decimator: field widths, register indexes,
// saturation limits and the sample-to-level function. No dependencies.
package wpd_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int LEVEL_BITS  = 16;
    localparam int INDEX_BITS  = 12;
    localparam int TOTAL_BITS  = 17;
    localparam int BARS_BITS   = 13;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 17;

    localparam logic [TOTAL_BITS-1:0] MAX_SAMPLES = TOTAL_BITS'(65536);
    localparam logic [BARS_BITS-1:0]  MAX_BARS    = BARS_BITS'(4096);

    // register indexes on the config port
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_BARS      = 2'd1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic [LEVEL_BITS-1:0]         t_level;
    typedef logic [INDEX_BITS-1:0]         t_bar_index;
    typedef logic [TOTAL_BITS-1:0]         t_total;
    typedef logic [BARS_BITS-1:0]          t_bars;

    // Magnitude; the most negative code maps to exactly full scale.
    function automatic t_level level_of(input t_sample s);
        logic [SAMPLE_BITS-1:0] raw;
        raw = s;
        return raw[SAMPLE_BITS-1] ? t_level'(~raw + 1'b1) : t_level'(raw);
    endfunction

endpackage

>>> src/wpd_ifs.sv
// Stream interfaces for the waveform peak decimator: sample in, bar out.
// Depends on wpd_pkg.
interface wpd_smp_if;
    logic             valid;
    logic             ready;
    wpd_pkg::t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface wpd_bar_if;
    logic                valid;
    logic                ready;
    wpd_pkg::t_level     level;
    wpd_pkg::t_bar_index bar_index;
    logic                last_bar;

    modport source (output valid, output level, output bar_index, output last_bar,
                    input ready);
    modport sink   (input valid, input level, input bar_index, input last_bar,
                    output ready);
endinterface

>>> src/waveform_peak_decimator.sv
// Waveform peak decimator top level: input register, bar update, result register.
// Depends on wpd_pkg and the stream interfaces in wpd_ifs.sv.
//
// Reduces a stream of N = total_samples signed Q1.15 samples to at most
// M = max_bars bars. Each sample becomes a level (its magnitude; -1.0 gives
// 32768). Bar i holds the peak level of samples floor(i*N/M) through
// floor((i+1)*N/M)-1; boundaries are tracked with a running remainder, so
// there is no divider. When N <= M every level is its own bar. The final bar
// of a stream carries last_bar, and the next sample starts a new stream.
// N above 65536 is taken as 65536; M is read from the low 13 data bits and
// above 4096 is taken as 4096. With N or M zero, samples are taken and
// dropped. Writing either register restarts the stream; write registers only
// while the block is idle. Throughput is one sample per clock while the output
// is not stalled; a sample goes input register, remainder/peak update, result
// register, each update done before the next sample is looked at. A stalled
// output holds back the input, with ready passed through combinationally.
module waveform_peak_decimator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wpd_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [wpd_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    wpd_smp_if.sink                        i_smp,
    wpd_bar_if.source                      o_bar
);

    // ---- configuration, stored already saturated ----
    wpd_pkg::t_total r_total;
    wpd_pkg::t_bars  r_bars;

    // ---- stream state ----
    wpd_pkg::t_total r_smp_cnt, n_smp_cnt;
    wpd_pkg::t_bars  r_bar_cnt, n_bar_cnt;
    wpd_pkg::t_level r_peak,    n_peak;
    wpd_pkg::t_total r_rem,     n_rem;

    // ---- input register ----
    logic             r_in_valid;
    wpd_pkg::t_sample r_sample;

    // ---- result register ----
    logic                r_out_valid;
    wpd_pkg::t_level     r_out_level, n_out_level;
    wpd_pkg::t_bar_index r_out_index;
    logic                r_out_last,  n_out_last;

    logic            out_free;
    logic            fire;
    logic            emit;
    logic            active;
    logic            pass_mode;
    wpd_pkg::t_level lvl;
    wpd_pkg::t_level peak_max;
    wpd_pkg::t_total m_ext;
    wpd_pkg::t_total rem_sub;
    wpd_pkg::t_total smp_inc;
    wpd_pkg::t_bars  bar_inc;
    logic            is_last;

    // Input register advances whenever the result register can take a beat.
    assign out_free    = !r_out_valid || o_bar.ready;
    assign fire        = r_in_valid && out_free;
    assign i_smp.ready = !r_in_valid || out_free;

    assign o_bar.valid     = r_out_valid;
    assign o_bar.level     = r_out_level;
    assign o_bar.bar_index = r_out_index;
    assign o_bar.last_bar  = r_out_last;

    // ---- bar update: one sample per cycle while the output is free ----
    always_comb begin
        active    = (r_total != '0) && (r_bars != '0);
        m_ext     = wpd_pkg::t_total'(r_bars);
        pass_mode = (r_total <= m_ext);
        lvl       = wpd_pkg::level_of(r_sample);
        peak_max  = (lvl > r_peak) ? lvl : r_peak;
        // remainder steps down by M per sample, floored at zero
        rem_sub   = (r_rem >= m_ext) ? (r_rem - m_ext) : '0;
        smp_inc   = wpd_pkg::t_total'(r_smp_cnt + 1'b1);
        bar_inc   = wpd_pkg::t_bars'(r_bar_cnt + 1'b1);

        n_smp_cnt   = r_smp_cnt;
        n_bar_cnt   = r_bar_cnt;
        n_peak      = r_peak;
        n_rem       = r_rem;
        emit        = 1'b0;
        is_last     = 1'b0;
        n_out_level = lvl;

        if (fire && active) begin
            n_smp_cnt = smp_inc;
            if (pass_mode) begin
                // every level is its own bar
                emit    = 1'b1;
                is_last = (smp_inc >= r_total);
            end else if (rem_sub < m_ext) begin
                // bar boundary: emit the peak, reload remainder
                emit        = 1'b1;
                n_out_level = peak_max;
                n_peak      = '0;
                n_rem       = wpd_pkg::t_total'(rem_sub + r_total);
                is_last     = (bar_inc >= r_bars) || (smp_inc >= r_total);
            end else begin
                n_peak = peak_max;
                n_rem  = rem_sub;
            end

            if (emit) begin
                if (is_last) begin
                    // end of stream: start over
                    n_smp_cnt = '0;
                    n_bar_cnt = '0;
                    n_peak    = '0;
                    n_rem     = r_total;
                end else begin
                    n_bar_cnt = bar_inc;
                end
            end
        end
        n_out_last = is_last;
    end

    // ---- config and stream state ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_bars    <= '0;
            r_smp_cnt <= '0;
            r_bar_cnt <= '0;
            r_peak    <= '0;
            r_rem     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wpd_pkg::CFG_TOTAL_SAMPLES: begin
                    r_total   <= (i_cfg_data > wpd_pkg::MAX_SAMPLES) ?
                                 wpd_pkg::MAX_SAMPLES : i_cfg_data;
                    r_smp_cnt <= '0;
                    r_bar_cnt <= '0;
                    r_peak    <= '0;
                    r_rem     <= (i_cfg_data > wpd_pkg::MAX_SAMPLES) ?
                                 wpd_pkg::MAX_SAMPLES : i_cfg_data;
                end
                wpd_pkg::CFG_MAX_BARS: begin
                    r_bars    <= (i_cfg_data[wpd_pkg::BARS_BITS-1:0] > wpd_pkg::MAX_BARS) ?
                                 wpd_pkg::MAX_BARS : i_cfg_data[wpd_pkg::BARS_BITS-1:0];
                    r_smp_cnt <= '0;
                    r_bar_cnt <= '0;
                    r_peak    <= '0;
                    r_rem     <= r_total;
                end
                default: begin
                    // index beyond the register list: ignored
                end
            endcase
        end else begin
            r_smp_cnt <= n_smp_cnt;
            r_bar_cnt <= n_bar_cnt;
            r_peak    <= n_peak;
            r_rem     <= n_rem;
        end
    end

    // ---- input register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_smp.ready) begin
            r_in_valid <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_sample <= i_smp.sample;
        end
    end

    // ---- result register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_bar.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_level <= n_out_level;
            r_out_index <= r_bar_cnt[wpd_pkg::INDEX_BITS-1:0];
            r_out_last  <= n_out_last;
        end
    end

    // ---- assertions ----
    // bar counter stays below the bar limit
    a_bar_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bars == '0) || (r_bar_cnt < r_bars))
        else $error("bar counter reached max_bars");

    // sample counter stays below the stream length
    a_smp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total == '0) || (r_smp_cnt < r_total))
        else $error("sample counter reached total_samples");

    // final bar clears the stream counters
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && n_out_last) |=> (r_smp_cnt == '0) && (r_bar_cnt == '0) && (r_peak == '0))
        else $error("stream not restarted after final bar");

endmodule
